@@ rtl/ftdd_pkg.sv @@
// ----------------------------------------------------------------------------
// ftdd_pkg
// Shared types and constants of the fraction to decimal digits unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ftdd_pkg;

   // operand and result widths
   localparam int DATA_W     = 32;
   localparam int CASE_W     = 32;
   localparam int CNT_W      = 6;
   localparam int STEP_W     = 6;
   localparam int DIGIT_W    = 4;
   localparam int TEN_W      = DATA_W + DIGIT_W;
   localparam int MAX_DIGITS = 63;

   // stream packing
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = CASE_W + DATA_W;
   localparam int KIND_W     = 2;

   // result kinds as seen on the result channel
   typedef enum logic [KIND_W-1:0] {
      KIND_INT   = 2'd0,
      KIND_DIGIT = 2'd1,
      KIND_TERM  = 2'd2
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT,
      ST_TEN
   } state_type;

endpackage

`default_nettype wire

@@ rtl/fraction_to_decimal_digits_unit.sv @@
// ----------------------------------------------------------------------------
// fraction_to_decimal_digits_unit
// Decimal expansion of a fraction by bit-serial long division.
// ----------------------------------------------------------------------------
// Usage
//   req channel carries one fraction per transfer: numerator, denominator and
//   digit count. An item with any zero field is an end marker and produces a
//   single terminator result (kind 2, value 0, tlast set).
//   rsp channel carries the results: first the integer quotient (kind 0), then
//   one transfer per fraction digit (kind 1); tlast marks the final digit,
//   which is rounded on the next digit and may read 10.
// Timing
//   all division work is done by one restoring divider that retires one
//   quotient bit per cycle. The integer part runs the divider over all 32
//   numerator bits; every further digit takes a times-ten step, a divider
//   pass over four quotient bits and an emit step.
//   A new request is taken as soon as the last result sits in the output
//   register, even while the receiver still holds that result.
// Reset and stall
//   reset clears the case counter and empties the output register. When the
//   receiver stalls, the unit waits with the next result ready in the
//   sequencer until the output register frees up; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_to_decimal_digits_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // numerator [31:0], denominator [63:32], digit_count [69:64], zero pad
   input  wire logic [ftdd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // case_number [31:0], value [63:32]
   output logic [ftdd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // kind [1:0]
   output logic [ftdd_pkg::KIND_W-1:0]              rsp_tuser,
   output logic                                     rsp_tlast
);
   import ftdd_pkg::*;

   // request fields
   logic [DATA_W-1:0] req_num;
   logic [DATA_W-1:0] req_den;
   logic [CNT_W-1:0]  req_cnt;
   logic [CNT_W-1:0]  req_cnt_cap;
   logic              req_marker;

   // sequencer and divider registers
   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [CASE_W-1:0] case_ff, case_in;
   kind_type          kind_ff, kind_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CASE_W-1:0] rsp_case_ff, rsp_case_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;

   // datapath helpers
   logic [DATA_W:0]   trial;
   logic              trial_ge;
   logic [DATA_W:0]   trial_diff;
   logic [TEN_W-1:0]  ten;
   logic              round_up;
   logic              is_last;
   logic              out_free;
   logic              req_xfer;

   // field unpacking
   assign req_num     = req_tdata[DATA_W-1:0];
   assign req_den     = req_tdata[2*DATA_W-1:DATA_W];
   assign req_cnt     = req_tdata[2*DATA_W+CNT_W-1:2*DATA_W];
   assign req_cnt_cap = (req_cnt > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : req_cnt;
   assign req_marker  = (req_num == '0) || (req_den == '0) || (req_cnt == '0);

   // one restoring division step: shift in next dividend bit, try subtract
   assign trial      = {rem_ff, quo_ff[DATA_W-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};

   // ten times the remainder, 8r + 2r
   assign ten = {1'b0, rem_ff, 3'b000} + {3'b000, rem_ff, 1'b0};

   // rounding of the final digit: next digit 5 or more when 2r >= b
   assign round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign is_last  = (kind_ff == KIND_TERM) || ((kind_ff == KIND_DIGIT) && (left_ff == CNT_W'(1)));

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      left_in      = left_ff;
      case_in      = case_ff;
      kind_in      = kind_ff;
      rsp_case_in  = rsp_case_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_marker) begin
                  kind_in  = KIND_TERM;
                  state_in = ST_EMIT;
               end else begin
                  case_in  = case_ff + CASE_W'(1);
                  den_in   = req_den;
                  rem_in   = '0;
                  quo_in   = req_num;
                  step_in  = STEP_W'(DATA_W);
                  left_in  = req_cnt_cap;
                  kind_in  = KIND_INT;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_in  = {quo_ff[DATA_W-2:0], trial_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_case_in  = case_ff;
               rsp_kind_in  = kind_ff;
               rsp_last_in  = is_last;
               case (kind_ff)
                  KIND_INT:   rsp_value_in = quo_ff;
                  KIND_DIGIT: rsp_value_in = DATA_W'(quo_ff[DIGIT_W-1:0])
                                           + DATA_W'(is_last && round_up);
                  default:    rsp_value_in = '0;
               endcase
               if (kind_ff == KIND_DIGIT) begin
                  left_in = left_ff - CNT_W'(1);
               end
               kind_in  = KIND_DIGIT;
               state_in = is_last ? ST_IDLE : ST_TEN;
            end
         end
         ST_TEN: begin
            // high bits preload the partial remainder, low bits still to divide
            rem_in   = ten[TEN_W-1:DIGIT_W];
            quo_in   = {ten[DIGIT_W-1:0], {(DATA_W-DIGIT_W){1'b0}}};
            step_in  = STEP_W'(DIGIT_W);
            state_in = ST_DIV;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         case_ff      <= '0;
         left_ff      <= '0;
         step_ff      <= '0;
         kind_ff      <= KIND_INT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case_ff      <= case_in;
         left_ff      <= left_in;
         step_ff      <= step_in;
         kind_ff      <= kind_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      den_ff       <= den_in;
      rsp_case_ff  <= rsp_case_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_value_ff, rsp_case_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // divider keeps the partial remainder below the divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_TEN) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

   // divider never runs with an exhausted step count
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff != '0))
      else $error("divider active with zero step count");

   // integer part is never the final result of a fraction
   a_int_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_INT) |-> !rsp_last_ff)
      else $error("integer result marked last");

   // a fraction digit reads at most ten after rounding
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_DIGIT) |-> (rsp_value_ff <= DATA_W'(10)))
      else $error("fraction digit out of range");

endmodule

`default_nettype wire

@@ test/fraction_to_decimal_digits_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fraction_to_decimal_digits_unit_tb
// Self-checking bench for the long division decimal expansion unit.
// A queue of fractions feeds a stream driver with random gaps. Every accepted
// request is expanded by a local long division predictor into the integer
// part, the digits and the rounded last digit. A monitor with random stalls,
// plus one long hold-off, checks each result transfer against the predictions.
// ----------------------------------------------------------------------------

module fraction_to_decimal_digits_unit_tb;
   import ftdd_pkg::*;

   // one fraction request
   typedef struct {
      logic [DATA_W-1:0] num;
      logic [DATA_W-1:0] den;
      logic [CNT_W-1:0]  count;
   } frac_req_type;

   // one result transfer
   typedef struct {
      logic [CASE_W-1:0] case_no;
      kind_type          kind;
      logic [DATA_W-1:0] value;
      logic              is_last;
   } digit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // numerator [31:0], denominator [63:32], digit_count [69:64], zero pad
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // case_number [31:0], value [63:32]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // kind [1:0]
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   // predictor state
   logic [CASE_W-1:0] case_tally = '0;
   logic [DATA_W-1:0] run_rem    = '0;
   logic [DATA_W-1:0] run_den    = '0;
   logic [CNT_W-1:0]  run_left   = '0;

   frac_req_type     pending_reqs[$];
   digit_result_type results_due[$];
   frac_req_type     on_bus;
   digit_result_type want;

   int unsigned sent_count     = 0;
   int unsigned seen_count     = 0;
   int unsigned marker_count   = 0;
   int unsigned mismatch_count = 0;
   int unsigned send_idle      = 0;
   int unsigned recv_idle      = 0;
   logic        hold_off       = 1'b0;

   fraction_to_decimal_digits_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always #2 clock = ~clock;

   // gap length: mostly none or short, a few long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // long division of one fraction into the expected result transfers
   function automatic void expand_fraction(input frac_req_type r);
      logic [DATA_W+3:0] ten_rem;
      logic [DATA_W-1:0] dig;
      if (r.num == '0 || r.den == '0 || r.count == '0) begin
         results_due.push_back('{case_tally, KIND_TERM, '0, 1'b1});
         marker_count++;
         return;
      end
      case_tally = case_tally + 1'b1;
      run_den    = r.den;
      run_rem    = r.num % r.den;
      run_left   = (r.count > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : r.count;
      results_due.push_back('{case_tally, KIND_INT, r.num / r.den, 1'b0});
      while (run_left != '0) begin
         ten_rem  = (DATA_W+4)'(run_rem) * 10;
         dig      = DATA_W'(ten_rem / run_den);
         run_rem  = DATA_W'(ten_rem % run_den);
         run_left = run_left - 1'b1;
         // round the final digit on the next one, no carry to the left
         if (run_left == '0 && {1'b0, run_rem, 1'b0} >= {2'b00, run_den})
            dig = dig + 1'b1;
         results_due.push_back('{case_tally, KIND_DIGIT, dig, run_left == '0});
      end
   endfunction

   // random fraction, now and then an end marker
   function automatic frac_req_type make_fraction();
      frac_req_type f;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      f.den = $urandom_range(1, 20);
      else if (pick < 60) f.den = $urandom;
      else if (pick < 80) f.den = $urandom_range(1, 1000);
      else if (pick < 90) f.den = 32'd1 << $urandom_range(0, 31);
      else                f.den = 32'hFFFF_FFFF - $urandom_range(0, 15);
      if (f.den == '0) f.den = 32'd1;
      pick = $urandom_range(0, 99);
      if (pick < 30)      f.num = 1 + ($urandom % f.den);
      else if (pick < 60) f.num = $urandom;
      else                f.num = $urandom_range(1, 200);
      if (f.num == '0) f.num = 32'd1;
      pick = $urandom_range(0, 99);
      if (pick < 70)      f.count = $urandom_range(1, 8);
      else if (pick < 90) f.count = $urandom_range(9, 30);
      else                f.count = $urandom_range(31, 63);
      // end marker with one or more zero fields
      if ($urandom_range(0, 99) < 10) begin
         pick = $urandom_range(1, 7);
         if (pick[0]) f.num   = '0;
         if (pick[1]) f.den   = '0;
         if (pick[2]) f.count = '0;
      end
      return f;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_idle = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            expand_fraction(on_bus);
            sent_count++;
         end
         if (send_idle != 0) begin
            send_idle--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            on_bus = pending_reqs.pop_front();
            req_tdata  <= {2'b00, on_bus.count, on_bus.den, on_bus.num};
            req_tvalid <= 1'b1;
            // every third stretch of 40 requests goes without gaps
            send_idle = (((sent_count / 40) % 3) == 1) ? 0 : idle_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_idle = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_count++;
            if (results_due.size() == 0) begin
               $error("result with nothing expected: case %0d kind %0d value %0d last %0b",
                      rsp_tdata[31:0], rsp_tuser, rsp_tdata[63:32], rsp_tlast);
               mismatch_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[31:0] !== want.case_no) begin
                  $error("case_number: expected %0d, actual %0d", want.case_no,
                         rsp_tdata[31:0]);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tdata[63:32] !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_tdata[63:32]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.is_last) begin
                  $error("last: expected %0b, actual %0b", want.is_last, rsp_tlast);
                  mismatch_count++;
               end
            end
            // every fourth stretch of 100 results goes without stalls
            recv_idle = (((seen_count / 100) % 4) == 3) ? 0 : idle_len();
         end
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (recv_idle != 0) begin
            recv_idle--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // long receiver hold-off so the unit backs up into its request side
   initial begin
      while (seen_count < 150) @(posedge clock);
      hold_off <= 1'b1;
      repeat (600) @(posedge clock);
      hold_off <= 1'b0;
   end

   // run limit
   initial begin
      #12_000_000;
      $display("timeout: %0d requests sent, %0d results seen", sent_count, seen_count);
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus and end of run
   initial begin
      // directed: extremes, rounding and end markers
      pending_reqs.push_back('{32'd1, 32'd3, 6'd5});
      pending_reqs.push_back('{32'd24, 32'd25, 6'd1});           // last digit reads 10
      pending_reqs.push_back('{32'd1, 32'd8, 6'd2});             // rounds at exactly half
      pending_reqs.push_back('{32'd1, 32'd8, 6'd1});             // below half, no round
      pending_reqs.push_back('{32'd7, 32'd2, 6'd1});             // exact, no round
      pending_reqs.push_back('{32'd2, 32'd3, 6'd1});
      pending_reqs.push_back('{32'hFFFF_FFFF, 32'd1, 6'd1});     // largest quotient
      pending_reqs.push_back('{32'd1, 32'hFFFF_FFFF, 6'd63});    // tiny fraction, max digits
      pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd3});
      pending_reqs.push_back('{32'hFFFF_FFFE, 32'hFFFF_FFFF, 6'd63}); // widest remainder
      pending_reqs.push_back('{32'd22, 32'd7, 6'd63});
      pending_reqs.push_back('{32'h8000_0000, 32'd3, 6'd10});
      pending_reqs.push_back('{32'd0, 32'd7, 6'd4});             // zero numerator
      pending_reqs.push_back('{32'd5, 32'd0, 6'd4});             // zero denominator
      pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0}); // zero count
      pending_reqs.push_back('{32'd0, 32'd0, 6'd0});
      pending_reqs.push_back('{32'd999, 32'd1000, 6'd2});
      pending_reqs.push_back('{32'd3, 32'd4, 6'd32});
      // random fractions
      repeat (250) pending_reqs.push_back(make_fraction());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid || results_due.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d requests: %0d fractions and %0d end markers",
               sent_count, sent_count - marker_count, marker_count);
      $display("checked %0d results under random gaps, stalls and one long hold-off",
               seen_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
